// ----- hdl/lspt_pkg.sv -----
// ============================================================================
// lspt_pkg
// Shared types, constants and helpers for the swing-leg trajectory evaluator.
// ============================================================================
`default_nettype none

package lspt_pkg;

   // Number of power cells in the chain: they produce t^2 through t^6.
   localparam int CELL_CNT = 5;

   // Width of the running smoothstep and bump sums inside the chain.
   localparam int ACC_W = 36;

   // Phase value that stands for t = 1.
   localparam logic [16:0] PHASE_ONE = 17'd65536;

   // Largest power value, 1.0 in Q0.30.
   localparam logic [30:0] Q30_ONE = 31'd1073741824;

   // Rounding offset of one half in Q0.30.
   localparam logic signed [65:0] Q30_HALF = 66'sd536870912;

   // Reset value of the lift register, 0.3 in Q16.16.
   localparam logic [30:0] SWING_HEIGHT_RST = 31'd19661;

   // Configuration register index.
   localparam logic REG_SWING_HEIGHT = 1'b0;

   // Input request fields.
   typedef struct packed {
      logic signed [31:0] start_x;
      logic signed [31:0] start_y;
      logic signed [31:0] start_z;
      logic signed [31:0] end_x;
      logic signed [31:0] end_y;
      logic signed [31:0] end_z;
      logic signed [31:0] cur_x;
      logic signed [31:0] cur_y;
      logic signed [31:0] cur_z;
      logic               is_swing;
      logic [16:0]        phase;
   } req_type;

   // Result fields.
   typedef struct packed {
      logic signed [31:0] foot_x;
      logic signed [31:0] foot_y;
      logic signed [31:0] foot_z;
      logic               saturated;
   } rsp_type;

   // Data handed from one power cell to the next.
   typedef struct packed {
      req_type                 pay;
      logic [16:0]             u;
      logic [30:0]             pw;
      logic signed [ACC_W-1:0] s_acc;
      logic signed [ACC_W-1:0] q_acc;
   } cell_data_type;

   // Smoothstep weight of the power that cell idx produces (t^(idx+1)).
   function automatic logic signed [4:0] cell_s_coef(input int idx);
      logic signed [4:0] c;
      case (idx)
         2: c = 5'sd10;
         3: c = -5'sd15;
         4: c = 5'sd6;
         default: c = 5'sd0;
      endcase
      return c;
   endfunction

   // Bump weight t^3(1-t)^3 of the power that cell idx produces.
   function automatic logic signed [4:0] cell_q_coef(input int idx);
      logic signed [4:0] c;
      case (idx)
         2: c = 5'sd1;
         3: c = -5'sd3;
         4: c = 5'sd3;
         5: c = -5'sd1;
         default: c = 5'sd0;
      endcase
      return c;
   endfunction

   // Clip a 37-bit value to the signed 32-bit range; the top bit flags a clip.
   function automatic logic [32:0] clip32(input logic signed [36:0] v);
      logic [32:0] r;
      if (v > 37'sd2147483647) begin
         r = {1'b1, 32'h7FFF_FFFF};
      end else if (v < -37'sd2147483648) begin
         r = {1'b1, 32'h8000_0000};
      end else begin
         r = {1'b0, v[31:0]};
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ----- hdl/lspt_cell.sv -----
// ============================================================================
// lspt_cell
// One cell of the power chain: multiplies the incoming power of t by t and
// adds the new power, weighted, into the smoothstep and bump sums.
// ============================================================================
`default_nettype none

module lspt_cell
   import lspt_pkg::*;
#(
   parameter int CELL_IDX = 1
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          in_valid,
   output logic               in_ready,
   input  wire cell_data_type in_data,
   output logic               out_valid,
   input  wire logic          out_ready,
   output cell_data_type      out_data
);

   localparam logic signed [4:0] S_COEF = cell_s_coef(CELL_IDX);
   localparam logic signed [4:0] Q_COEF = cell_q_coef(CELL_IDX);

   logic          valid_ff;
   logic          valid_in;
   cell_data_type data_ff;
   cell_data_type data_in;
   logic [47:0]   prod;
   logic [30:0]   npw;
   logic signed [36:0] s_term;
   logic signed [36:0] q_term;

   // The stage takes a new request when empty or when its contents move on.
   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   // Next power of t, floored back to Q0.30.
   assign prod   = in_data.pw * in_data.u;
   assign npw    = prod[46:16];
   assign s_term = S_COEF * $signed({1'b0, npw});
   assign q_term = Q_COEF * $signed({1'b0, npw});

   always_comb begin
      data_in       = in_data;
      data_in.pw    = npw;
      data_in.s_acc = in_data.s_acc + s_term[ACC_W-1:0];
      data_in.q_acc = in_data.q_acc + q_term[ACC_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   // Powers of a clamped phase never exceed one.
   a_pw_range: assert property (@(posedge clock) disable iff (reset)
      out_valid |-> out_data.pw <= Q30_ONE)
      else $error("power of t above one");

   // The phase reaching a cell is already clamped.
   a_u_range: assert property (@(posedge clock) disable iff (reset)
      out_valid |-> out_data.u <= PHASE_ONE)
      else $error("unclamped phase in chain");

   // A held request stays in the cell until the next one takes it.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      out_valid && !out_ready |=> out_valid && $stable(out_data))
      else $error("cell dropped a held request");

endmodule

`default_nettype wire

// ----- hdl/lspt_blend.sv -----
// ============================================================================
// lspt_blend
// Forms the axis weights, multiplies them by the travel of each axis, rounds,
// adds the start position and saturates into the result register; a stance leg passes its position through.
// ============================================================================
`default_nettype none

module lspt_blend
   import lspt_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic [30:0]   swing_height,
   input  wire logic          in_valid,
   output logic               in_ready,
   input  wire cell_data_type in_data,
   output logic               rsp_valid,
   input  wire logic          rsp_stall,
   output rsp_type            rsp_data
);

   // Weight stage.
   logic               w_valid_ff, w_valid_in, w_ready;
   req_type            w_pay_ff;
   logic signed [31:0] w_s_ff, w_g_ff, w_w_ff;
   logic signed [32:0] w_dx_ff, w_dy_ff, w_dz_ff;
   logic signed [40:0] g_full;
   logic signed [40:0] w_full;

   // Multiply stage.
   logic               m_valid_ff, m_valid_in, m_ready;
   req_type            m_pay_ff;
   logic signed [64:0] m_px_ff, m_py_ff, m_pz_ff;
   logic signed [63:0] m_ph_ff;
   logic signed [64:0] px, py, pz;
   logic signed [63:0] ph;

   // Sum and rounding-offset stage.
   logic               a_valid_ff, a_valid_in, a_ready;
   req_type            a_pay_ff;
   logic signed [65:0] a_vx_ff, a_vy_ff, a_vz_ff;

   // Final stage and result register.
   logic               f_ready;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;
   logic               rsp_swing_ff;
   logic signed [36:0] rx, ry, rz;
   logic [32:0]        cx, cy, cz;

   // Ready ripples back from the result register.
   assign f_ready  = !rsp_valid_ff || !rsp_stall;
   assign a_ready  = !a_valid_ff || f_ready;
   assign m_ready  = !m_valid_ff || a_ready;
   assign w_ready  = !w_valid_ff || m_ready;
   assign in_ready = w_ready;

   assign w_valid_in   = w_ready ? in_valid : w_valid_ff;
   assign m_valid_in   = m_ready ? w_valid_ff : m_valid_ff;
   assign a_valid_in   = a_ready ? m_valid_ff : a_valid_ff;
   assign rsp_valid_in = f_ready ? a_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         w_valid_ff   <= 1'b0;
         m_valid_ff   <= 1'b0;
         a_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         w_valid_ff   <= w_valid_in;
         m_valid_ff   <= m_valid_in;
         a_valid_ff   <= a_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Weights: g = s + 32q for z travel, w = 64q for the lift; both fit 32 bits.
   assign g_full = {{5{in_data.s_acc[ACC_W-1]}}, in_data.s_acc} + {in_data.q_acc, 5'b0};
   assign w_full = {in_data.q_acc, 5'b0} + {in_data.q_acc, 5'b0};

   always_ff @(posedge clock) begin
      if (in_valid && w_ready) begin
         w_pay_ff <= in_data.pay;
         w_s_ff   <= in_data.s_acc[31:0];
         w_g_ff   <= g_full[31:0];
         w_w_ff   <= w_full[31:0];
         w_dx_ff  <= {in_data.pay.end_x[31], in_data.pay.end_x}
                     - {in_data.pay.start_x[31], in_data.pay.start_x};
         w_dy_ff  <= {in_data.pay.end_y[31], in_data.pay.end_y}
                     - {in_data.pay.start_y[31], in_data.pay.start_y};
         w_dz_ff  <= {in_data.pay.end_z[31], in_data.pay.end_z}
                     - {in_data.pay.start_z[31], in_data.pay.start_z};
      end
   end

   // One multiplier per product.
   assign px = w_dx_ff * w_s_ff;
   assign py = w_dy_ff * w_s_ff;
   assign pz = w_dz_ff * w_g_ff;
   assign ph = $signed({1'b0, swing_height}) * w_w_ff;

   always_ff @(posedge clock) begin
      if (w_valid_ff && m_ready) begin
         m_pay_ff <= w_pay_ff;
         m_px_ff  <= px;
         m_py_ff  <= py;
         m_pz_ff  <= pz;
         m_ph_ff  <= ph;
      end
   end

   // Add the lift term for z and the rounding half on every axis.
   always_ff @(posedge clock) begin
      if (m_valid_ff && a_ready) begin
         a_pay_ff <= m_pay_ff;
         a_vx_ff  <= {m_px_ff[64], m_px_ff} + Q30_HALF;
         a_vy_ff  <= {m_py_ff[64], m_py_ff} + Q30_HALF;
         a_vz_ff  <= {m_pz_ff[64], m_pz_ff} + {{2{m_ph_ff[63]}}, m_ph_ff} + Q30_HALF;
      end
   end

   // Floor by 2^30 is the upper bits; then add the start and clip.
   assign rx = {{5{a_pay_ff.start_x[31]}}, a_pay_ff.start_x} + {a_vx_ff[65], a_vx_ff[65:30]};
   assign ry = {{5{a_pay_ff.start_y[31]}}, a_pay_ff.start_y} + {a_vy_ff[65], a_vy_ff[65:30]};
   assign rz = {{5{a_pay_ff.start_z[31]}}, a_pay_ff.start_z} + {a_vz_ff[65], a_vz_ff[65:30]};
   assign cx = clip32(rx);
   assign cy = clip32(ry);
   assign cz = clip32(rz);

   // A stance leg passes its present position through.
   always_comb begin
      if (a_pay_ff.is_swing) begin
         rsp_in.foot_x    = cx[31:0];
         rsp_in.foot_y    = cy[31:0];
         rsp_in.foot_z    = cz[31:0];
         rsp_in.saturated = cx[32] | cy[32] | cz[32];
      end else begin
         rsp_in.foot_x    = a_pay_ff.cur_x;
         rsp_in.foot_y    = a_pay_ff.cur_y;
         rsp_in.foot_z    = a_pay_ff.cur_z;
         rsp_in.saturated = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (a_valid_ff && f_ready) begin
         rsp_ff       <= rsp_in;
         rsp_swing_ff <= a_pay_ff.is_swing;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // No result is shown in the cycle after reset.
   a_rst_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // A stance leg never reports saturation.
   a_stance_sat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_swing_ff |-> !rsp_data.saturated)
      else $error("stance leg flagged as saturated");

   // With every stage full and the output stalled, nothing more is taken.
   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      w_valid_ff && m_valid_ff && a_valid_ff && rsp_valid_ff && rsp_stall |-> !in_ready)
      else $error("request taken into a full, stalled pipeline");

endmodule

`default_nettype wire

// ----- hdl/leg_swing_polynomial_trajectory.sv -----
// ============================================================================
// leg_swing_polynomial_trajectory
// Swing-leg foot trajectory evaluator on a sixth-order polynomial in phase.
// ============================================================================
//
//  Channel  Direction  Handshake          Payload
//  req      in         req_valid/stall    req_type: start, end, cur, swing, phase
//  rsp      out        rsp_valid/stall    rsp_type: foot x/y/z, saturated
//  csr      in/out     APB psel/penable   swing_height at byte address 0
//
//  One request enters per cycle while rsp is not stalled; each result passes
//  through the five power cells and then the weight, multiply, sum and clip stages.
//  Reset clears all valid bits and loads swing_height with 0.3.
//  A stall on rsp freezes only the stages that are full, so bubbles still fill.
//
`default_nettype none

module leg_swing_polynomial_trajectory
   import lspt_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire req_type     req_data,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output rsp_type          rsp_data,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   logic [30:0]   swing_height_ff;
   logic [30:0]   swing_height_in;
   logic [16:0]   u_clamp;
   cell_data_type chain_data  [0:CELL_CNT];
   logic          chain_valid [0:CELL_CNT];
   logic          chain_ready [0:CELL_CNT];

   // Configuration register.
   assign csr_pready = 1'b1;

   always_comb begin
      swing_height_in = swing_height_ff;
      if (csr_psel && csr_penable && csr_pwrite && (csr_paddr[2] == REG_SWING_HEIGHT)) begin
         swing_height_in = csr_pwdata[30:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         swing_height_ff <= SWING_HEIGHT_RST;
      end else begin
         swing_height_ff <= swing_height_in;
      end
   end

   always_comb begin
      if (csr_paddr[2] == REG_SWING_HEIGHT) begin
         csr_prdata = {1'b0, swing_height_ff};
      end else begin
         csr_prdata = 32'd0;
      end
   end

   // Chain head: clamp the phase and enter t itself as a Q0.30 power.
   assign u_clamp = (req_data.phase > PHASE_ONE) ? PHASE_ONE : req_data.phase;

   always_comb begin
      chain_data[0].pay   = req_data;
      chain_data[0].u     = u_clamp;
      chain_data[0].pw    = {u_clamp, 14'd0};
      chain_data[0].s_acc = '0;
      chain_data[0].q_acc = '0;
   end

   assign chain_valid[0] = req_valid;
   assign req_stall      = !chain_ready[0];

   // Row of power cells producing t^2 .. t^6.
   for (genvar i = 1; i <= CELL_CNT; i++) begin : g_cell
      lspt_cell #(
         .CELL_IDX (i)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (chain_valid[i-1]),
         .in_ready  (chain_ready[i-1]),
         .in_data   (chain_data[i-1]),
         .out_valid (chain_valid[i]),
         .out_ready (chain_ready[i]),
         .out_data  (chain_data[i])
      );
   end

   // Weighting, rounding and saturation.
   lspt_blend u_blend (
      .clock        (clock),
      .reset        (reset),
      .swing_height (swing_height_ff),
      .in_valid     (chain_valid[CELL_CNT]),
      .in_ready     (chain_ready[CELL_CNT]),
      .in_data      (chain_data[CELL_CNT]),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_data     (rsp_data)
   );

endmodule

`default_nettype wire
